>>> sv/bgpr_pkg.sv
// ============================================================================
// bgpr_pkg
// Shared types and constants for the bitmap glyph pixel renderer.
// ============================================================================
package bgpr_pkg;

    // Default build parameters
    localparam int GLYPH_COUNT_DEF    = 256;
    localparam int GLYPH_ROWS_MAX_DEF = 8;
    localparam int MAX_FB_DIM_DEF     = 4096;

    // Font layout: eight byte rows per glyph
    localparam int FONT_ROW_BYTES = 8;

    // Width used for clip limit arithmetic (covers MAX_FB_DIM up to 65535)
    localparam int LIM_W = 16;

    // Only this depth draws
    localparam logic [7:0] BPP_DRAW = 8'd32;

    // Glyph size default and cap
    localparam logic [3:0] GLYPH_DIM_DEF = 4'd8;
    localparam logic [3:0] GLYPH_DIM_CAP = 4'd8;

    // Item commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_DRAW  = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] REG_DRAWING_ENABLED = 3'd0;
    localparam logic [2:0] REG_FB_BASE         = 3'd1;
    localparam logic [2:0] REG_FB_WIDTH        = 3'd2;
    localparam logic [2:0] REG_FB_HEIGHT       = 3'd3;
    localparam logic [2:0] REG_ROW_PITCH       = 3'd4;
    localparam logic [2:0] REG_BITS_PER_PIXEL  = 3'd5;
    localparam logic [2:0] REG_CHAR_COLS       = 3'd6;
    localparam logic [2:0] REG_CHAR_ROWS       = 3'd7;

    typedef struct packed {
        logic        cmd;
        logic [10:0] font_addr;
        logic [7:0]  font_byte;
        logic [7:0]  char_code;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic [31:0] fg_color;
        logic [31:0] bg_color;
    } req_t;

    typedef struct packed {
        logic [31:0] pixel_addr;
        logic [31:0] pixel_color;
        logic        last_pixel;
    } pix_t;

    typedef struct packed {
        logic        drawing_enabled;
        logic [31:0] fb_base;
        logic [12:0] fb_width;
        logic [12:0] fb_height;
        logic [15:0] row_pitch;
        logic [7:0]  bits_per_pixel;
        logic [3:0]  char_cols;
        logic [3:0]  char_rows;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_ADDR,
        ST_FETCH,
        ST_EMIT
    } state_t;

endpackage

>>> sv/bitmap_glyph_pixel_renderer_unit.sv
// ============================================================================
// bitmap_glyph_pixel_renderer_unit
// Bitmap font character generator: font RAM plus per-pixel write sequencer.
// ============================================================================
// An item is taken when start is high and busy is low. A font write item
// (cmd 0) stores one byte in the font RAM in its accept cycle, if font_addr
// is below the font depth, and busy stays low, so the next item may follow
// at once. A draw item (cmd 1) passes through the setup states SETUP (clip
// extent with the y*pitch multiply) and ADDR (start address), then for each
// visible glyph row through a font RAM read state (FETCH) followed by one
// pixel per cycle. The rate is set by the single font RAM read port (one
// glyph row per fetch) and the one-pixel-per-cycle output. A fully clipped
// glyph goes from SETUP back to idle and emits nothing; a draw item while
// drawing is disabled or depth is not 32 is taken with busy staying low and
// emits nothing. Each pixel is on the pixel ports for exactly one cycle
// with pixel_valid high; the receiver cannot stall it, so it must take
// every pixel as it comes. last_pixel marks the final pixel of a character.
// Configuration is written through cfg_we/cfg_index/cfg_data and must only
// change while busy is low. Font RAM contents are undefined until written.
// ============================================================================
module bitmap_glyph_pixel_renderer_unit #(
    parameter int GLYPH_COUNT    = bgpr_pkg::GLYPH_COUNT_DEF,
    parameter int GLYPH_ROWS_MAX = bgpr_pkg::GLYPH_ROWS_MAX_DEF,
    parameter int MAX_FB_DIM     = bgpr_pkg::MAX_FB_DIM_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  bgpr_pkg::req_t request,
    output logic           pixel_valid,
    output bgpr_pkg::pix_t pixel,
    input  logic           cfg_we,
    input  logic [2:0]     cfg_index,
    input  logic [31:0]    cfg_data
);
    import bgpr_pkg::*;

    // Font RAM: GLYPH_COUNT glyphs of eight byte rows
    localparam int FONT_DEPTH = GLYPH_COUNT * FONT_ROW_BYTES;
    localparam int FONT_AW    = $clog2(FONT_DEPTH);

    cfg_t               cfg;
    logic               ram_we;
    logic [FONT_AW-1:0] ram_waddr;
    logic [7:0]         ram_wdata;
    logic               ram_re;
    logic [FONT_AW-1:0] ram_raddr;
    logic [7:0]         ram_rdata;

    // Register file; the user must keep values steady while a draw is in progress, the block does not enforce it
    bgpr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Font store with registered read
    bgpr_ram #(
        .WIDTH  (8),
        .DEPTH  (FONT_DEPTH),
        .ADDR_W (FONT_AW)
    ) u_font_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequencer: writes go straight to the RAM, draws walk the glyph
    bgpr_draw #(
        .GLYPH_COUNT    (GLYPH_COUNT),
        .GLYPH_ROWS_MAX (GLYPH_ROWS_MAX),
        .MAX_FB_DIM     (MAX_FB_DIM),
        .FONT_DEPTH     (FONT_DEPTH),
        .FONT_AW        (FONT_AW)
    ) u_draw (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .request     (request),
        .cfg         (cfg),
        .pixel_valid (pixel_valid),
        .pixel       (pixel),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata)
    );

endmodule

>>> sv/bgpr_ram.sv
// ============================================================================
// bgpr_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ============================================================================
module bgpr_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/bgpr_cfg.sv
// ============================================================================
// bgpr_cfg
// Configuration register file, written through a plain write port.
// ============================================================================
module bgpr_cfg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [31:0]   cfg_data,
    output bgpr_pkg::cfg_t cfg
);
    import bgpr_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_DRAWING_ENABLED: cfg_next.drawing_enabled = cfg_data[0];
                REG_FB_BASE:         cfg_next.fb_base         = cfg_data;
                REG_FB_WIDTH:        cfg_next.fb_width        = cfg_data[12:0];
                REG_FB_HEIGHT:       cfg_next.fb_height       = cfg_data[12:0];
                REG_ROW_PITCH:       cfg_next.row_pitch       = cfg_data[15:0];
                REG_BITS_PER_PIXEL:  cfg_next.bits_per_pixel  = cfg_data[7:0];
                REG_CHAR_COLS:       cfg_next.char_cols       = cfg_data[3:0];
                REG_CHAR_ROWS:       cfg_next.char_rows       = cfg_data[3:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.drawing_enabled <= 1'b0;
            cfg_reg.fb_base         <= '0;
            cfg_reg.fb_width        <= '0;
            cfg_reg.fb_height       <= '0;
            cfg_reg.row_pitch       <= '0;
            cfg_reg.bits_per_pixel  <= '0;
            cfg_reg.char_cols       <= GLYPH_DIM_DEF;
            cfg_reg.char_rows       <= GLYPH_DIM_DEF;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> sv/bgpr_draw.sv
// ============================================================================
// bgpr_draw
// Item sequencer: font writes, glyph clipping, row fetch and pixel emission.
// ============================================================================
module bgpr_draw #(
    parameter int GLYPH_COUNT    = bgpr_pkg::GLYPH_COUNT_DEF,
    parameter int GLYPH_ROWS_MAX = bgpr_pkg::GLYPH_ROWS_MAX_DEF,
    parameter int MAX_FB_DIM     = bgpr_pkg::MAX_FB_DIM_DEF,
    parameter int FONT_DEPTH     = GLYPH_COUNT * bgpr_pkg::FONT_ROW_BYTES,
    parameter int FONT_AW        = $clog2(FONT_DEPTH)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  bgpr_pkg::req_t     request,
    input  bgpr_pkg::cfg_t     cfg,
    output logic               pixel_valid,
    output bgpr_pkg::pix_t     pixel,
    output logic               ram_we,
    output logic [FONT_AW-1:0] ram_waddr,
    output logic [7:0]         ram_wdata,
    output logic               ram_re,
    output logic [FONT_AW-1:0] ram_raddr,
    input  logic [7:0]         ram_rdata
);
    import bgpr_pkg::*;

    localparam logic [LIM_W-1:0] DIM_LIM  = LIM_W'(MAX_FB_DIM);
    localparam logic [3:0]       ROWS_LIM = 4'(GLYPH_ROWS_MAX);

    state_t state_reg, state_next;

    // Payload latched at draw accept
    logic [7:0]  code_reg;
    logic        code_ok_reg;
    logic [11:0] px_reg;
    logic [11:0] py_reg;
    logic [31:0] fg_reg;
    logic [31:0] bg_reg;

    // Walk state
    logic [3:0]  vcols_reg, vcols_next;
    logic [3:0]  vrows_reg, vrows_next;
    logic [27:0] prod_reg, prod_next;
    logic [31:0] row_addr_reg;
    logic [31:0] pix_addr_reg;
    logic [2:0]  row_reg;
    logic [2:0]  col_reg;

    logic accept, draw_go, col_last, row_last, empty;
    logic [3:0]       cols_eff, rows_raw, rows_eff;
    logic [LIM_W-1:0] wlim, hlim, wavail, havail, pxe, pye;
    logic [10:0]      glyph_row_idx;

    assign accept   = start && (state_reg == ST_IDLE);
    assign draw_go  = accept && (request.cmd == CMD_DRAW) && cfg.drawing_enabled
                      && (cfg.bits_per_pixel == BPP_DRAW);
    assign col_last = ({1'b0, col_reg} == (vcols_reg - 4'd1));
    assign row_last = ({1'b0, row_reg} == (vrows_reg - 4'd1));

    // Visible extent of the glyph after size caps and clipping
    always_comb
    begin
        cols_eff = (cfg.char_cols == 4'd0 || cfg.char_cols > GLYPH_DIM_CAP)
                   ? GLYPH_DIM_CAP : cfg.char_cols;
        rows_raw = (cfg.char_rows == 4'd0 || cfg.char_rows > GLYPH_DIM_CAP)
                   ? GLYPH_DIM_CAP : cfg.char_rows;
        rows_eff = (rows_raw > ROWS_LIM) ? ROWS_LIM : rows_raw;
        wlim     = (LIM_W'(cfg.fb_width) > DIM_LIM) ? DIM_LIM : LIM_W'(cfg.fb_width);
        hlim     = (LIM_W'(cfg.fb_height) > DIM_LIM) ? DIM_LIM : LIM_W'(cfg.fb_height);
        pxe      = LIM_W'(px_reg);
        pye      = LIM_W'(py_reg);
        wavail   = (wlim > pxe) ? (wlim - pxe) : '0;
        havail   = (hlim > pye) ? (hlim - pye) : '0;
        vcols_next = (wavail < LIM_W'(cols_eff)) ? wavail[3:0] : cols_eff;
        vrows_next = (havail < LIM_W'(rows_eff)) ? havail[3:0] : rows_eff;
        empty      = (vcols_next == 4'd0) || (vrows_next == 4'd0);
        prod_next  = 28'(py_reg) * 28'(cfg.row_pitch);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  state_next = draw_go ? ST_SETUP : ST_IDLE;
            ST_SETUP: state_next = empty ? ST_IDLE : ST_ADDR;
            ST_ADDR:  state_next = ST_FETCH;
            ST_FETCH: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (col_last)
                begin
                    state_next = row_last ? ST_IDLE : ST_FETCH;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        busy        = 1'b1;
        pixel_valid = 1'b0;
        ram_re      = 1'b0;
        ram_we      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy   = 1'b0;
                ram_we = accept && (request.cmd == CMD_WRITE)
                         && (12'(request.font_addr) < 12'(FONT_DEPTH));
            end
            ST_FETCH: ram_re = 1'b1;
            ST_EMIT:  pixel_valid = 1'b1;
            default:  busy = 1'b1;
        endcase
    end

    assign ram_waddr     = request.font_addr[FONT_AW-1:0];
    assign ram_wdata     = request.font_byte;
    assign glyph_row_idx = {code_reg, row_reg};
    assign ram_raddr     = glyph_row_idx[FONT_AW-1:0];

    // Bit 7 of the row is the leftmost column
    assign pixel.pixel_addr  = pix_addr_reg;
    assign pixel.pixel_color = (code_ok_reg && ram_rdata[~col_reg]) ? fg_reg : bg_reg;
    assign pixel.last_pixel  = col_last && row_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (draw_go)
                begin
                    code_reg    <= request.char_code;
                    code_ok_reg <= 9'(request.char_code) < 9'(GLYPH_COUNT);
                    px_reg      <= request.pos_x;
                    py_reg      <= request.pos_y;
                    fg_reg      <= request.fg_color;
                    bg_reg      <= request.bg_color;
                end
            end
            ST_SETUP:
            begin
                vcols_reg <= vcols_next;
                vrows_reg <= vrows_next;
                prod_reg  <= prod_next;
                row_reg   <= '0;
            end
            ST_ADDR:
            begin
                row_addr_reg <= cfg.fb_base + 32'(prod_reg) + 32'({px_reg, 2'b00});
            end
            ST_FETCH:
            begin
                pix_addr_reg <= row_addr_reg;
                col_reg      <= '0;
            end
            ST_EMIT:
            begin
                pix_addr_reg <= pix_addr_reg + 32'd4;
                col_reg      <= col_reg + 3'd1;
                if (col_last)
                begin
                    row_reg      <= row_reg + 3'd1;
                    row_addr_reg <= row_addr_reg + 32'(cfg.row_pitch);
                end
            end
            default:
            begin
                row_reg <= row_reg;
            end
        endcase
    end

endmodule
